[design/tp_pkg.sv]
package tp_pkg;

   localparam logic [1:0] TP_KIND_CAPTURE = 2'd0;
   localparam logic [1:0] TP_KIND_TICK    = 2'd1;
   localparam logic [1:0] TP_KIND_READ    = 2'd2;

   localparam logic [7:0]  TP_OVF_STOP   = 8'd128;
   localparam logic [7:0]  TP_OVF_LIMIT  = 8'd127;
   localparam logic [23:0] TP_MIN_PERIOD = 24'd7325;
   localparam logic [15:0] TP_RAMP_NUM   = 16'd7325;
   localparam logic [28:0] TP_QRPM_NUM   = 29'd480000000;
   localparam logic [15:0] TP_TOO_FAST   = 16'hFFFF;
   localparam logic [15:0] TP_STALLED    = 16'd0;

   localparam int unsigned TP_QUOT_BITS = 16;

   typedef struct packed {
      logic [7:0]  ovf;
      logic [7:0]  period_high;
      logic [15:0] period_low;
   } tp_meas_type;

   typedef struct packed {
      logic [23:0] rem_init;
      logic [15:0] dividend;
      logic [23:0] divisor;
   } tp_div_load_type;

   typedef enum logic [1:0] {
      TP_IDLE,
      TP_DIV,
      TP_SEND
   } tp_fsm_type;

endpackage

[design/tp_period.sv]
module tp_period import tp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        capture,
   input  logic        tick,
   input  logic [15:0] timer_snap,
   output tp_meas_type meas
);

   logic [7:0]  ovf_ff, ovf_in;
   logic [15:0] last_ff, last_in;
   logic [7:0]  high_ff, high_in;
   logic [15:0] low_ff, low_in;
   logic [8:0]  ovf_next;

   assign ovf_next = {1'b0, ovf_ff} + 9'd1;

   always_comb begin
      ovf_in  = ovf_ff;
      last_in = last_ff;
      high_in = high_ff;
      low_in  = low_ff;
      if (capture) begin
         low_in  = timer_snap - last_ff;
         // borrow from the overflow count when the timer wrapped
         high_in = (timer_snap < last_ff) ? ovf_ff - 8'd1 : ovf_ff;
         ovf_in  = 8'd0;
         last_in = timer_snap;
      end else if (tick) begin
         ovf_in = (ovf_next > {1'b0, TP_OVF_LIMIT}) ? TP_OVF_STOP : ovf_next[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff  <= TP_OVF_STOP;
         last_ff <= 16'd0;
         high_ff <= 8'd0;
         low_ff  <= 16'd0;
      end else begin
         ovf_ff  <= ovf_in;
         last_ff <= last_in;
         high_ff <= high_in;
         low_ff  <= low_in;
      end
   end

   assign meas.ovf         = ovf_ff;
   assign meas.period_high = high_ff;
   assign meas.period_low  = low_ff;

endmodule

[design/tp_div.sv]
module tp_div import tp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  tp_div_load_type load,
   output logic            done,
   output logic [15:0]     quotient
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [23:0] rem_ff, rem_in;
   logic [15:0] dq_ff, dq_in;
   logic [23:0] div_ff, div_in;
   logic [24:0] shifted;
   logic [25:0] diff;
   logic        fits;

   // one quotient bit per cycle, shifted in where the dividend bits leave
   assign shifted = {rem_ff, dq_ff[15]};
   assign diff    = {1'b0, shifted} - {2'b00, div_ff};
   assign fits    = ~diff[25];

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      div_in  = div_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = 4'(TP_QUOT_BITS - 1);
         rem_in = load.rem_init;
         dq_in  = load.dividend;
         div_in = load.divisor;
      end else if (run_ff) begin
         rem_in = fits ? diff[23:0] : shifted[23:0];
         dq_in  = {dq_ff[14:0], fits};
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

[design/tach_period_rpm.sv]
// Tachometer period to speed. Each req_ transfer is one event: a capture edge
// with the timer count, a timer overflow tick, or a speed read; kind 3 is
// ignored. Captures, ticks and kind 3 give no result and leave req_tready high, so
// they can follow back to back. A read gives one rsp_ transfer with speed in
// quarter RPM: stalled and too-fast reads go from idle to the send state, all
// others run a restoring divider that makes one quotient bit per cycle for a
// 16-bit quotient and then go to the send state; from the send state the result
// enters the output register once it is free. req_tready stays low from the read
// until then, and longer while the previous result still waits downstream. The next request
// is taken from the edge after the result has moved to the output register, even
// if it has not yet been taken downstream.
module tach_period_rpm import tp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] timer_snap
   input  logic [1:0]  req_tuser,  // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // [15:0] quarter_rpm
);

   tp_fsm_type      state_ff, state_in;
   logic [15:0]     res_ff, res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [15:0]     rsp_data_ff, rsp_data_in;
   logic            req_xfer;
   logic            capture, tick, read;
   logic            div_start, div_done;
   logic [15:0]     div_quot;
   tp_div_load_type div_load;
   tp_meas_type     meas;
   logic            stalled, slowing, too_fast;

   assign req_tready = (state_ff == TP_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign capture    = req_xfer & (req_tuser == TP_KIND_CAPTURE);
   assign tick       = req_xfer & (req_tuser == TP_KIND_TICK);
   assign read       = req_xfer & (req_tuser == TP_KIND_READ);

   tp_period u_period (
      .clock      (clock),
      .reset      (reset),
      .capture    (capture),
      .tick       (tick),
      .timer_snap (req_tdata),
      .meas       (meas)
   );

   assign stalled  = (meas.ovf > TP_OVF_LIMIT);
   assign slowing  = (meas.ovf > meas.period_high);
   assign too_fast = ({meas.period_high, meas.period_low} < TP_MIN_PERIOD);

   always_comb begin
      if (slowing) begin
         div_load.rem_init = 24'd0;
         div_load.dividend = TP_RAMP_NUM;
         div_load.divisor  = {16'd0, meas.ovf};
      end else begin
         // top bits of the numerator are below any period that reaches here
         div_load.rem_init = {11'd0, TP_QRPM_NUM[28:16]};
         div_load.dividend = TP_QRPM_NUM[15:0];
         div_load.divisor  = {meas.period_high, meas.period_low};
      end
   end

   tp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .load     (div_load),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      case (state_ff)
         TP_IDLE: begin
            if (read) begin
               if (stalled) begin
                  res_in   = TP_STALLED;
                  state_in = TP_SEND;
               end else if (!slowing && too_fast) begin
                  res_in   = TP_TOO_FAST;
                  state_in = TP_SEND;
               end else begin
                  div_start = 1'b1;
                  state_in  = TP_DIV;
               end
            end
         end
         TP_DIV: begin
            if (div_done) begin
               res_in   = div_quot;
               state_in = TP_SEND;
            end
         end
         TP_SEND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = TP_IDLE;
            end
         end
         default: begin
            state_in = TP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_read_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      read |=> (state_ff != TP_IDLE))
      else $error("read transfer did not start a result");

   a_rsp_from_send: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == TP_SEND))
      else $error("result appeared without a send step");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == TP_DIV))
      else $error("divider finished outside of a division");

   a_ovf_bound: assert property (@(posedge clock) disable iff (reset)
      meas.ovf <= TP_OVF_STOP)
      else $error("overflow count beyond its limit");

endmodule
